// File: rtl/core/ssq_pkg.sv
// Shared types and constants for the sorted sleep queue timer.
`default_nettype none

package ssq_pkg;

    // Field widths fixed by the request and result words
    localparam int TIME_W = 32;
    localparam int TASK_W = 8;

    // Default sizing of the sleep store
    localparam int DEFAULT_QUEUE_DEPTH   = 64;
    localparam int DEFAULT_TASK_ID_WIDTH = 8;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_DELAY = 2'd0,
        OP_UNTIL = 2'd1,
        OP_TIME  = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    // Result kind codes
    typedef enum logic [1:0] {
        KIND_WAKE = 2'd0,
        KIND_TIME = 2'd1,
        KIND_FULL = 2'd2
    } kind_t;

endpackage

`default_nettype wire

// File: rtl/core/ssq_mem.sv
// Sleep store memory: wake time and task id per slot, one write and one read port.
`default_nettype none

module ssq_mem
    import ssq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH,
    parameter int TASK_ID_WIDTH = DEFAULT_TASK_ID_WIDTH
) (
    input  wire logic                             clk,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]   rd_addr,
    output logic      [TIME_W-1:0]                rd_wake,
    output logic      [TASK_ID_WIDTH-1:0]         rd_id,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]   wr_addr,
    input  wire logic [TIME_W-1:0]                wr_wake,
    input  wire logic [TASK_ID_WIDTH-1:0]         wr_id
);

    logic [TIME_W-1:0]        wake_mem [QUEUE_DEPTH];
    logic [TASK_ID_WIDTH-1:0] id_mem   [QUEUE_DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wake_mem[wr_addr] <= wr_wake;
            id_mem[wr_addr]   <= wr_id;
        end
    end

    // Registered read port, data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_wake <= wake_mem[rd_addr];
            rd_id   <= id_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sorted_sleep_queue_timer_core.sv
// Top level: request decode, sorted insert and tick release sequencer, result register.
`default_nettype none

// Sleeping tasks live in a circular buffer in one memory, sorted by wake
// time from the head; ties keep insertion order. One request is taken at a
// time. A time reply or queue-full error goes out through the reply state;
// a delay into an empty store is written directly, otherwise every queued
// entry with a later wake time is read, compared and moved up one slot,
// one per cycle through the memory's single read port, before the new one
// is written. A tick releases expired tasks from the head, one wake word
// per cycle unless the output stalls; a full result register sits on
// the output, so a stalled consumer only holds the sequencer when it has a
// new word to hand over. Memory contents need no clearing after reset.
module sorted_sleep_queue_timer_core
    import ssq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH,
    parameter int TASK_ID_WIDTH = DEFAULT_TASK_ID_WIDTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        op,
    input  wire logic [TASK_W-1:0] task_id,
    input  wire logic [TIME_W-1:0] amount,
    input  wire logic [TIME_W-1:0] now,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             kind,
    output logic [TASK_W-1:0]      reply_task,
    output logic [TIME_W-1:0]      reply_time,
    output logic                   last
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = TASK_ID_WIDTH;
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [AW-1:0] ONE_A   = AW'(1);
    localparam logic [AW-1:0] TWO_A   = AW'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_TICK_CMP,
        S_REPLY
    } state_t;

    // Logical slot to physical address, wrapping around the buffer end
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] l);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, l};
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    // Stored id back to the reply field width
    function automatic logic [TASK_W-1:0] id_out(input logic [IW-1:0] id);
        logic [IW+TASK_W-1:0] x;
        x = {{TASK_W{1'b0}}, id};
        return x[TASK_W-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     p_reg, p_next;
    logic [TIME_W-1:0] when_reg, when_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [IW-1:0]     id_reg, id_next;
    kind_t             rkind_reg, rkind_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IW-1:0]     pend_id_reg, pend_id_next;
    logic              out_valid_reg, out_valid_next;
    kind_t             out_kind_reg, out_kind_next;
    logic [TASK_W-1:0] out_task_reg, out_task_next;
    logic [TIME_W-1:0] out_time_reg, out_time_next;
    logic              out_last_reg, out_last_next;

    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [TIME_W-1:0] mem_rd_wake;
    logic [IW-1:0]     mem_rd_id;
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [TIME_W-1:0] mem_wr_wake;
    logic [IW-1:0]     mem_wr_id;

    logic              emit;
    kind_t             emit_kind;
    logic [IW-1:0]     emit_id;
    logic              emit_last;
    logic              can_emit;
    logic              expired;
    logic [IW+TASK_W-1:0] in_id_ext;
    logic [IW-1:0]     in_id;
    logic [TIME_W:0]   rel_sum;
    logic [TIME_W-1:0] rel_when;
    logic [TIME_W-1:0] req_when;
    logic [AW-1:0]     cnt_lo;

    ssq_mem #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .TASK_ID_WIDTH (TASK_ID_WIDTH)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_wake (mem_rd_wake),
        .rd_id   (mem_rd_id),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_wake (mem_wr_wake),
        .wr_id   (mem_wr_id)
    );

    // Request decode helpers
    assign in_id_ext = {{IW{1'b0}}, task_id};
    assign in_id     = in_id_ext[IW-1:0];
    assign rel_sum   = {1'b0, now} + {1'b0, amount};
    assign rel_when  = rel_sum[TIME_W] ? {TIME_W{1'b1}} : rel_sum[TIME_W-1:0];
    assign req_when  = (op_t'(op) == OP_DELAY) ? rel_when : amount;
    assign cnt_lo    = cnt_reg[AW-1:0];
    assign can_emit  = !out_valid_reg || out_ready;
    assign expired   = (cnt_reg != '0) && (mem_rd_wake <= now_reg);
    assign in_ready  = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        cnt_next        = cnt_reg;
        p_next          = p_reg;
        when_next       = when_reg;
        now_next        = now_reg;
        id_next         = id_reg;
        rkind_next      = rkind_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = head_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = head_reg;
        mem_wr_wake     = when_reg;
        mem_wr_id       = id_reg;
        emit            = 1'b0;
        emit_kind       = KIND_WAKE;
        emit_id         = id_reg;
        emit_last       = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    id_next  = in_id;
                    now_next = now;
                    case (op_t'(op))
                        OP_DELAY, OP_UNTIL:
                        begin
                            when_next = req_when;
                            if (cnt_reg == DEPTH_C)
                            begin
                                rkind_next = KIND_FULL;
                                state_next = S_REPLY;
                            end
                            else if (cnt_reg == '0)
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = head_reg;
                                mem_wr_wake = req_when;
                                mem_wr_id   = in_id;
                                cnt_next    = ONE_C;
                            end
                            else
                            begin
                                // walk back from the tail
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = phys(head_reg, cnt_lo - ONE_A);
                                p_next      = cnt_lo;
                                state_next  = S_INS_CMP;
                            end
                        end
                        OP_TIME:
                        begin
                            rkind_next = KIND_TIME;
                            state_next = S_REPLY;
                        end
                        default:
                        begin
                            if (cnt_reg != '0)
                            begin
                                mem_rd_en       = 1'b1;
                                mem_rd_addr     = head_reg;
                                pend_valid_next = 1'b0;
                                state_next      = S_TICK_CMP;
                            end
                        end
                    endcase
                end
            end

            S_INS_CMP:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = phys(head_reg, p_reg);
                if (mem_rd_wake > when_reg)
                begin
                    // later entry moves up one slot
                    mem_wr_wake = mem_rd_wake;
                    mem_wr_id   = mem_rd_id;
                    p_next      = p_reg - ONE_A;
                    if (p_reg == ONE_A)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = phys(head_reg, p_reg - TWO_A);
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + ONE_C;
                    state_next = S_IDLE;
                end
            end

            S_INS_PUT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = phys(head_reg, p_reg);
                cnt_next    = cnt_reg + ONE_C;
                state_next  = S_IDLE;
            end

            S_TICK_CMP:
            begin
                // a pending wake word goes out once the next entry tells if it is last
                if (expired)
                begin
                    if (!pend_valid_reg || can_emit)
                    begin
                        emit            = pend_valid_reg;
                        emit_id         = pend_id_reg;
                        emit_last       = 1'b0;
                        pend_valid_next = 1'b1;
                        pend_id_next    = mem_rd_id;
                        head_next       = phys(head_reg, ONE_A);
                        cnt_next        = cnt_reg - ONE_C;
                        mem_rd_en       = 1'b1;
                        mem_rd_addr     = phys(head_reg, ONE_A);
                    end
                end
                else if (pend_valid_reg)
                begin
                    if (can_emit)
                    begin
                        emit            = 1'b1;
                        emit_id         = pend_id_reg;
                        emit_last       = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_REPLY:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    emit_kind  = rkind_reg;
                    emit_id    = id_reg;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_task_next  = out_task_reg;
        out_time_next  = out_time_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = emit_kind;
            out_task_next  = id_out(emit_id);
            out_time_next  = now_reg;
            out_last_next  = emit_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        when_reg     <= when_next;
        now_reg      <= now_next;
        id_reg       <= id_next;
        rkind_reg    <= rkind_next;
        pend_id_reg  <= pend_id_next;
        out_kind_reg <= out_kind_next;
        out_task_reg <= out_task_next;
        out_time_reg <= out_time_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign kind       = out_kind_reg;
    assign reply_task = out_task_reg;
    assign reply_time = out_time_reg;
    assign last       = out_last_reg;

`ifndef NO_ASSERTIONS
    // store never holds more than its depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("entry count above queue depth");

    // an insert grows the store by exactly one
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg > $past(cnt_reg)) |-> (cnt_reg == $past(cnt_reg) + ONE_C))
        else $error("entry count grew by more than one");

    // the insert walk never runs below slot zero
    a_walk_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_CMP) |-> (p_reg != '0))
        else $error("insert walk at slot zero");

    // time replies and errors are single words
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg != KIND_WAKE) |-> out_last_reg)
        else $error("non-wake word without last");

    // a time request goes straight to the reply state
    a_time_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op_t'(op) == OP_TIME) |=> (state_reg == S_REPLY))
        else $error("time request not answered");
`endif

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Testbench for the sorted sleep queue timer core: directed and random requests checked by a predictor.
`timescale 1ns / 1ps

module tb_top;
    import ssq_pkg::*;

    localparam int DEPTH        = DEFAULT_QUEUE_DEPTH;
    localparam int HOLD_CYCLES  = 250;
    localparam int CALM_CYCLES  = 1000;
    localparam int DRAIN_CYCLES = 200;
    localparam int IDLE_PCT     = 18;
    localparam int ITEM_TARGET  = 158;

    // One request word, plus driver controls
    typedef struct {
        op_t         op;
        logic [7:0]  tid;
        logic [31:0] amount;
        logic [31:0] stamp;
        bit          pause;   // wait here until every reply is back
        bit          quiet;   // send without idle gaps
    } request_t;

    // One reply word
    typedef struct {
        kind_t       kind;
        logic [7:0]  tid;
        logic [31:0] stamp;
        logic        last;
    } reply_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic [1:0]        op         = '0;
    logic [TASK_W-1:0] task_id    = '0;
    logic [TIME_W-1:0] amount     = '0;
    logic [TIME_W-1:0] now        = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic [1:0]        kind;
    logic [TASK_W-1:0] reply_task;
    logic [TIME_W-1:0] reply_time;
    logic              last;

    // Sleep store mirror, sorted by wake time, ties in arrival order
    logic [31:0] sleep_when[$];
    logic [7:0]  sleep_tid[$];

    request_t    req_q[$];
    reply_t      replies_due[$];

    int          errors    = 0;
    bit          took      = 1'b0;
    bit          hold_arm  = 1'b0;
    bit          hold_used = 1'b0;
    int          hold_left = 0;
    int          calm_left = 0;
    logic [31:0] clock_ticks;

    sorted_sleep_queue_timer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .task_id    (task_id),
        .amount     (amount),
        .now        (now),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .reply_task (reply_task),
        .reply_time (reply_time),
        .last       (last)
    );

    always #5 clk = ~clk;

    // Update the store mirror for one accepted request and queue its replies
    task automatic timer_predict(input request_t r);
        logic [32:0] sum;
        logic [31:0] wake;
        reply_t      rep;
        int          pos;
        int          woken;
        rep.tid   = r.tid;
        rep.stamp = r.stamp;
        rep.last  = 1'b1;
        case (r.op)
            OP_DELAY, OP_UNTIL:
            begin
                sum  = {1'b0, r.stamp} + {1'b0, r.amount};
                wake = (r.op == OP_UNTIL) ? r.amount : (sum[32] ? '1 : sum[31:0]);
                if (sleep_when.size() >= DEPTH)
                begin
                    rep.kind = KIND_FULL;
                    replies_due.push_back(rep);
                end
                else
                begin
                    pos = 0;
                    while (pos < sleep_when.size() && sleep_when[pos] <= wake)
                        pos++;
                    sleep_when.insert(pos, wake);
                    sleep_tid.insert(pos, r.tid);
                end
            end
            OP_TIME:
            begin
                rep.kind = KIND_TIME;
                replies_due.push_back(rep);
            end
            default:
            begin
                // tick: release every expired sleeper from the head
                woken    = 0;
                rep.kind = KIND_WAKE;
                rep.last = 1'b0;
                while (sleep_when.size() > 0 && sleep_when[0] <= r.stamp)
                begin
                    void'(sleep_when.pop_front());
                    rep.tid = sleep_tid.pop_front();
                    replies_due.push_back(rep);
                    woken++;
                end
                if (woken > 0)
                    replies_due[replies_due.size() - 1].last = 1'b1;
            end
        endcase
    endtask

    task automatic add_req(input op_t o, input logic [7:0] t, input logic [31:0] a,
                           input logic [31:0] s, input bit q);
        request_t r;
        r.op     = o;
        r.tid    = t;
        r.amount = a;
        r.stamp  = s;
        r.pause  = 1'b0;
        r.quiet  = q;
        req_q.push_back(r);
    endtask

    // Sampling at the rising edge: check replies, predict accepted requests
    always @(posedge clk)
    begin
        reply_t   exp_rep;
        request_t acc;
        took = 1'b0;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: unexpected reply kind %0d task %0d time %0d last %0d",
                             $time, kind, reply_task, reply_time, last);
                    errors++;
                end
                else
                begin
                    exp_rep = replies_due.pop_front();
                    if (kind !== exp_rep.kind)
                    begin
                        $display("%0t: kind expected %0d, actual %0d", $time, exp_rep.kind, kind);
                        errors++;
                    end
                    if (reply_task !== exp_rep.tid)
                    begin
                        $display("%0t: reply_task expected %0d, actual %0d",
                                 $time, exp_rep.tid, reply_task);
                        errors++;
                    end
                    if (reply_time !== exp_rep.stamp)
                    begin
                        $display("%0t: reply_time expected %0d, actual %0d",
                                 $time, exp_rep.stamp, reply_time);
                        errors++;
                    end
                    if (last !== exp_rep.last)
                    begin
                        $display("%0t: last expected %0d, actual %0d", $time, exp_rep.last, last);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                took       = 1'b1;
                acc.op     = op_t'(op);
                acc.tid    = task_id;
                acc.amount = amount;
                acc.stamp  = now;
                acc.pause  = 1'b0;
                acc.quiet  = 1'b0;
                timer_predict(acc);
            end
        end
    end

    // Request driver: holds a word until taken, then offers the next one
    always @(negedge clk)
    begin
        request_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || took)
        begin
            if (req_q.size() > 0 && req_q[0].pause)
            begin
                // sender pause: resume once every reply has drained
                if (replies_due.size() == 0)
                begin
                    void'(req_q.pop_front());
                    hold_arm <= 1'b1;
                end
                in_valid <= 1'b0;
            end
            else if (req_q.size() > 0 &&
                     (req_q[0].quiet || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                nxt = req_q.pop_front();
                op       <= nxt.op;
                task_id  <= nxt.tid;
                amount   <= nxt.amount;
                now      <= nxt.stamp;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Reply receiver: random stalls, one long hold-off, then a calm window
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_arm && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            calm_left <= CALM_CYCLES;
            out_ready <= 1'b0;
        end
        else if (calm_left > 0)
        begin
            calm_left <= calm_left - 1;
            out_ready <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Stimulus, reset and end of run
    initial
    begin
        request_t pause_mark;
        int       grp;
        int       burst;

        // Directed: extremes, each operation, saturation, ties, empty tick
        add_req(OP_TIME,  8'd0,   32'd0,          32'd0,          1'b0);
        add_req(OP_TIME,  8'd255, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0);
        add_req(OP_TICK,  8'd7,   32'd0,          32'd0,          1'b0);
        add_req(OP_DELAY, 8'd1,   32'd0,          32'd100,        1'b0);
        add_req(OP_DELAY, 8'd2,   32'hFFFF_FFFF,  32'd5,          1'b0);
        add_req(OP_UNTIL, 8'd3,   32'd100,        32'd10,         1'b0);
        add_req(OP_UNTIL, 8'd4,   32'd0,          32'd20,         1'b0);
        add_req(OP_UNTIL, 8'd255, 32'hFFFF_FFFF,  32'd30,         1'b0);
        add_req(OP_DELAY, 8'd5,   32'd50,         32'd0,          1'b0);
        add_req(OP_TIME,  8'hAA,  32'h5555_5555,  32'hAAAA_AAAA,  1'b0);
        add_req(OP_TICK,  8'h55,  32'hAAAA_AAAA,  32'd49,         1'b0);
        add_req(OP_TICK,  8'd0,   32'd0,          32'd100,        1'b0);
        add_req(OP_TICK,  8'd0,   32'd0,          32'hFFFF_FFFE,  1'b0);
        add_req(OP_TICK,  8'd0,   32'd0,          32'hFFFF_FFFF,  1'b0);

        // Fill the store past capacity without sender gaps
        clock_ticks = 32'd1000;
        for (int i = 0; i < DEPTH + 2; i++)
        begin
            if (i % 2)
                add_req(OP_UNTIL, 8'($urandom_range(0, 255)),
                        clock_ticks + $urandom_range(0, 500), clock_ticks, 1'b1);
            else
                add_req(OP_DELAY, 8'($urandom_range(0, 255)),
                        $urandom_range(0, 500), clock_ticks, 1'b1);
        end

        // Drain fully, then time reads against a long receiver hold-off
        pause_mark       = req_q[0];
        pause_mark.pause = 1'b1;
        req_q.push_back(pause_mark);
        for (int i = 0; i < 10; i++)
            add_req(OP_TIME, 8'($urandom_range(0, 255)), $urandom, clock_ticks, 1'b0);

        // Release the whole store at once
        clock_ticks = clock_ticks + 600;
        add_req(OP_TICK, 8'($urandom_range(0, 255)), $urandom, clock_ticks, 1'b0);

        // Random groups: mostly sleep bursts and advancing ticks, some noise
        while (req_q.size() < ITEM_TARGET)
        begin
            grp = $urandom_range(0, 9);
            if (grp <= 3)
            begin
                burst = $urandom_range(1, 12);
                for (int i = 0; i < burst; i++)
                    if ($urandom_range(0, 1))
                        add_req(OP_DELAY, 8'($urandom_range(0, 255)),
                                $urandom_range(0, 300), clock_ticks, 1'b0);
                    else
                        add_req(OP_UNTIL, 8'($urandom_range(0, 255)),
                                clock_ticks + $urandom_range(0, 300), clock_ticks, 1'b0);
            end
            else if (grp <= 6)
            begin
                clock_ticks = clock_ticks + $urandom_range(0, 200);
                add_req(OP_TICK, 8'($urandom_range(0, 255)), $urandom, clock_ticks, 1'b0);
            end
            else if (grp == 7)
                add_req(OP_TIME, 8'($urandom_range(0, 255)), $urandom, clock_ticks, 1'b0);
            else if (grp == 8)
                add_req(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        $urandom, $urandom, 1'b0);
            else
            begin
                burst = $urandom_range(20, 50);
                for (int i = 0; i < burst; i++)
                    add_req(OP_DELAY, 8'($urandom_range(0, 255)),
                            $urandom_range(0, 400), clock_ticks, 1'b0);
                clock_ticks = clock_ticks + $urandom_range(100, 300);
                add_req(OP_TICK, 8'($urandom_range(0, 255)), $urandom, clock_ticks, 1'b0);
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (req_q.size() != 0 || in_valid || replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
